@@ hdl/ltc_pkg.sv @@
// Shared constants and types for the LRU tag cache directory.
package ltc_pkg;

  // Default geometry of the directory.
  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned STAMP_BITS = 32;

  // Fixed field widths of the register and result ports.
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned SLOT_W = 6;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Summary flags that the scan engine reports at the end of a pass.
  typedef struct packed {
    logic found;      // a valid entry matched the request key
    logic have_min;   // at least one valid entry was seen
    logic have_free;  // at least one free entry was seen
  } ltc_scan_stat_t;

endpackage

@@ hdl/ltc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module ltc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ltc_scan.sv @@
// Scan engine: walks the tag/stamp memory once, finding the match, LRU entry and free slot.
module ltc_scan #(
  parameter int unsigned ENTRIES    = ltc_pkg::ENTRIES,
  parameter int unsigned KEY_BITS   = ltc_pkg::KEY_BITS,
  parameter int unsigned STAMP_BITS = ltc_pkg::STAMP_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [KEY_BITS-1:0]            key_i,
  input  logic [ENTRIES-1:0]             valid_i,
  output logic [$clog2(ENTRIES)-1:0]     raddr_o,
  input  logic [KEY_BITS+STAMP_BITS-1:0] rdata_i,
  output logic                           done_o,
  output ltc_pkg::ltc_scan_stat_t        stat_o,
  output logic [$clog2(ENTRIES)-1:0]     match_idx_o,
  output logic [$clog2(ENTRIES)-1:0]     min_idx_o,
  output logic [KEY_BITS-1:0]            min_key_o,
  output logic [$clog2(ENTRIES)-1:0]     free_idx_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                    rd_act_q, rd_act_d;
  logic [IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic                    cmp_act_q, cmp_act_d;
  logic [IDX_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic                    done_q, done_d;
  ltc_pkg::ltc_scan_stat_t stat_q, stat_d;
  logic [IDX_W-1:0]        match_idx_q, match_idx_d;
  logic [IDX_W-1:0]        min_idx_q, min_idx_d;
  logic [STAMP_BITS-1:0]   min_stamp_q, min_stamp_d;
  logic [KEY_BITS-1:0]     min_key_q, min_key_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;

  logic [KEY_BITS-1:0]     beat_tag;
  logic [STAMP_BITS-1:0]   beat_stamp;
  logic                    beat_valid;

  assign beat_tag   = rdata_i[KEY_BITS+STAMP_BITS-1:STAMP_BITS];
  assign beat_stamp = rdata_i[STAMP_BITS-1:0];
  assign beat_valid = valid_i[cmp_idx_q];

  always_comb begin
    rd_act_d    = rd_act_q;
    rd_idx_d    = rd_idx_q;
    cmp_act_d   = rd_act_q;
    cmp_idx_d   = rd_idx_q;
    done_d      = cmp_act_q && (cmp_idx_q == LAST_IDX);
    stat_d      = stat_q;
    match_idx_d = match_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    min_key_d   = min_key_q;
    free_idx_d  = free_idx_q;

    if (start_i) begin
      rd_act_d = 1'b1;
      rd_idx_d = '0;
      stat_d   = '0;
    end else if (rd_act_q) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
      if (rd_idx_q == LAST_IDX) begin
        rd_act_d = 1'b0;
      end
    end

    if (cmp_act_q) begin
      if (beat_valid && (beat_tag == key_i) && !stat_q.found) begin
        stat_d.found = 1'b1;
        match_idx_d  = cmp_idx_q;
      end
      // Strict less-than keeps the lowest slot among equal stamps.
      if (beat_valid && (!stat_q.have_min || (beat_stamp < min_stamp_q))) begin
        stat_d.have_min = 1'b1;
        min_idx_d       = cmp_idx_q;
        min_stamp_d     = beat_stamp;
        min_key_d       = beat_tag;
      end
      if (!beat_valid && !stat_q.have_free) begin
        stat_d.have_free = 1'b1;
        free_idx_d       = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q  <= 1'b0;
      rd_idx_q  <= '0;
      cmp_act_q <= 1'b0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
      stat_q    <= '0;
    end else begin
      rd_act_q  <= rd_act_d;
      rd_idx_q  <= rd_idx_d;
      cmp_act_q <= cmp_act_d;
      cmp_idx_q <= cmp_idx_d;
      done_q    <= done_d;
      stat_q    <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    min_key_q   <= min_key_d;
    free_idx_q  <= free_idx_d;
  end

  assign raddr_o     = rd_idx_q;
  assign done_o      = done_q;
  assign stat_o      = stat_q;
  assign match_idx_o = match_idx_q;
  assign min_idx_o   = min_idx_q;
  assign min_key_o   = min_key_q;
  assign free_idx_o  = free_idx_q;

endmodule

@@ hdl/lru_tag_cache.sv @@
// Top level of the fully associative LRU tag cache directory.
//
// A request is taken at a rising edge with start high and busy low; busy then
// stays high while the block reads every entry of the tag/stamp memory once,
// one entry per cycle through its single read port, compares tags and keeps
// the least recently used entry and the lowest free slot. A request holds
// busy for the whole memory scan and the update, so a new request is taken
// only after the last one is through; the memory scan sets this pace.
// The result appears on hit_o, slot_o, evicted_o and evicted_key_o for exactly
// one cycle with done_o high, in the first cycle in which busy is low again.
// The receiver cannot stall, so a result must be captured in the cycle it is
// shown.
// The capacity register is written through its own valid/ready channel,
// which is always ready; write it only while the block is idle. A capacity
// of zero behaves as one, and a value above ENTRIES behaves as the full
// directory. Entry valid bits live in flip-flops and clear at reset, so
// no clearing pass is needed; the tag/stamp memory holds no reset value.
module lru_tag_cache #(
  parameter int unsigned ENTRIES    = ltc_pkg::ENTRIES,
  parameter int unsigned KEY_BITS   = ltc_pkg::KEY_BITS,
  parameter int unsigned STAMP_BITS = ltc_pkg::STAMP_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [KEY_BITS-1:0]        key_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [ltc_pkg::SLOT_W-1:0] slot_o,
  output logic                       evicted_o,
  output logic [KEY_BITS-1:0]        evicted_key_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ltc_pkg::CAP_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  // Width wide enough to compare the count against the capacity register.
  localparam int unsigned CMP_W = (CNT_W > ltc_pkg::CAP_W) ? CNT_W : ltc_pkg::CAP_W;
  localparam int unsigned WORD_W = KEY_BITS + STAMP_BITS;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                    state_q, state_d;
  logic [ltc_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [STAMP_BITS-1:0]     clock_q, clock_d;
  logic [KEY_BITS-1:0]       key_q, key_d;
  logic [STAMP_BITS-1:0]     stamp_q, stamp_d;
  logic                      done_q, done_d;
  logic                      hit_q, hit_d;
  logic [IDX_W-1:0]          slot_q, slot_d;
  logic                      evicted_q, evicted_d;
  logic [KEY_BITS-1:0]       evicted_key_q, evicted_key_d;

  logic                      accept;
  logic                      scan_done;
  ltc_pkg::ltc_scan_stat_t   scan_stat;
  logic [IDX_W-1:0]          match_idx;
  logic [IDX_W-1:0]          min_idx;
  logic [KEY_BITS-1:0]       min_key;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          ram_raddr;
  logic [WORD_W-1:0]         ram_rdata;
  logic                      ram_we;

  logic [CMP_W-1:0]          cap_ext;
  logic [CMP_W-1:0]          cap_eff;
  logic                      full;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Clamp the capacity register into the range the directory can hold.
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full = (CMP_W'(count_q) >= cap_eff) && (count_q != '0);

  ltc_scan #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .key_i       (key_q),
    .valid_i     (valid_q),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .done_o      (scan_done),
    .stat_o      (scan_stat),
    .match_idx_o (match_idx),
    .min_idx_o   (min_idx),
    .min_key_o   (min_key),
    .free_idx_o  (free_idx)
  );

  // The tag and its use stamp share one memory word; the update writes both.
  ltc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_d),
    .wdata_i ({key_q, stamp_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_we = (state_q == S_SCAN) && scan_done;

  always_comb begin
    state_d       = state_q;
    cap_d         = cap_q;
    valid_d       = valid_q;
    count_d       = count_q;
    clock_d       = clock_q;
    key_d         = key_q;
    stamp_d       = stamp_q;
    done_d        = 1'b0;
    hit_d         = hit_q;
    slot_d        = slot_q;
    evicted_d     = evicted_q;
    evicted_key_d = evicted_key_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Each request takes the current clock as its stamp.
          key_d   = key_i;
          stamp_d = clock_q;
          clock_d = clock_q + STAMP_BITS'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          done_d        = 1'b1;
          state_d       = S_IDLE;
          evicted_d     = 1'b0;
          evicted_key_d = '0;
          if (scan_stat.found) begin
            // Hit: only the stamp changes; the tag is rewritten unchanged.
            hit_d  = 1'b1;
            slot_d = match_idx;
          end else if (full) begin
            // Miss with a full directory: reuse the least recently used slot.
            // The count stays where it is since one entry leaves and one comes.
            hit_d         = 1'b0;
            slot_d        = min_idx;
            evicted_d     = 1'b1;
            evicted_key_d = min_key;
          end else begin
            // Miss with room left: fill the lowest free slot.
            hit_d            = 1'b0;
            slot_d           = free_idx;
            valid_d[free_idx] = 1'b1;
            count_d          = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= ltc_pkg::CAP_RESET;
      valid_q <= '0;
      count_q <= '0;
      clock_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      valid_q <= valid_d;
      count_q <= count_d;
      clock_q <= clock_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    stamp_q       <= stamp_d;
    hit_q         <= hit_d;
    slot_q        <= slot_d;
    evicted_q     <= evicted_d;
    evicted_key_q <= evicted_key_d;
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign slot_o        = ltc_pkg::SLOT_W'(slot_q);
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

`ifndef ASSERT_OFF
  // The fill count always equals the number of valid entries.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count differs from number of valid entries");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !evicted_o)
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted key reads as zero.
  a_evkey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_key_o == '0))
    else $error("evicted key nonzero without an eviction");

  // A result is shown only right after a scan finished.
  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(scan_done))
    else $error("result strobe without a finished scan");
`endif

endmodule

@@ verif/lru_tag_cache_test.sv @@
// Self-checking testbench for the LRU tag cache directory.
`timescale 1ns / 100ps

module lru_tag_cache_test;

  localparam int unsigned ENTRIES    = ltc_pkg::ENTRIES;
  localparam int unsigned KEY_BITS   = ltc_pkg::KEY_BITS;
  localparam int unsigned STAMP_BITS = ltc_pkg::STAMP_BITS;
  localparam int unsigned SLOT_W     = ltc_pkg::SLOT_W;
  localparam int unsigned CAP_W      = ltc_pkg::CAP_W;

  // The run stops here if the block hangs. The slowest correct run is about
  // 1750 requests, each with its busy time and the longest sender gap, plus
  // short pauses around every capacity change. This limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  // Cycles to watch for stray results once every expected one has arrived.
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
  localparam int unsigned MAX_REPORTS = 10;

  // What one lookup should report, together with the key that caused it.
  typedef struct {
    logic [KEY_BITS-1:0] key;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [KEY_BITS-1:0] evicted_key;
  } cache_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KEY_BITS-1:0] key_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [SLOT_W-1:0]   slot_o;
  logic                evicted_o;
  logic [KEY_BITS-1:0] evicted_key_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i = '0;

  lru_tag_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .key_i         (key_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .slot_o        (slot_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the directory. It is advanced once per accepted request,
  // in the same order as the block sees the requests.
  bit                    dir_valid [ENTRIES];
  logic [KEY_BITS-1:0]   dir_tag   [ENTRIES];
  logic [STAMP_BITS-1:0] dir_stamp [ENTRIES];
  int unsigned           dir_count;
  logic [STAMP_BITS-1:0] use_clock;
  logic [CAP_W-1:0]      capacity_reg;

  logic [KEY_BITS-1:0] key_queue [$];    // requests waiting for the driver
  cache_outcome_t      outcome_q [$];    // outcomes of accepted requests
  int unsigned         issued_count;     // requests handed to the driver
  int unsigned         served_count;     // requests whose result came back
  int unsigned         mismatches;
  int unsigned         cycle_count;
  bit                  req_taken;        // a request was accepted at the last edge
  int unsigned         burst_left = 1;
  int unsigned         gap_left;

  // A capacity of zero acts as one, anything above the directory size acts
  // as the whole directory.
  function automatic int unsigned effective_capacity();
    int unsigned lim;
    lim = capacity_reg;
    if (lim < 1) lim = 1;
    if (lim > ENTRIES) lim = ENTRIES;
    return lim;
  endfunction

  // Looks the key up in the shadow directory, updates it and returns what
  // the block must report for this request.
  function automatic cache_outcome_t predict_access(logic [KEY_BITS-1:0] k);
    cache_outcome_t        r;
    logic [STAMP_BITS-1:0] now;
    logic [STAMP_BITS-1:0] oldest;
    bit                    seen;
    bit                    placed;
    r.key = k;
    r.hit = 1'b0;
    r.slot = '0;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    now = use_clock;
    use_clock = use_clock + 1'b1;

    for (int i = 0; i < ENTRIES; i++) begin
      if (!r.hit && dir_valid[i] && dir_tag[i] == k) begin
        r.hit = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end

    if (r.hit) begin
      dir_stamp[r.slot] = now;
    end else begin
      // Full (or over-full after the capacity was lowered): replace the
      // entry with the oldest stamp, lowest slot on a tie.
      if (dir_count >= effective_capacity() && dir_count > 0) begin
        seen = 1'b0;
        oldest = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && (!seen || dir_stamp[i] < oldest)) begin
            seen = 1'b1;
            oldest = dir_stamp[i];
            r.slot = SLOT_W'(i);
          end
        end
        if (seen) begin
          r.evicted = 1'b1;
          r.evicted_key = dir_tag[r.slot];
          dir_valid[r.slot] = 1'b0;
          dir_count--;
        end
      end
      if (!r.evicted) begin
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!placed && !dir_valid[i]) begin
            placed = 1'b1;
            r.slot = SLOT_W'(i);
          end
        end
      end
      dir_valid[r.slot] = 1'b1;
      dir_tag[r.slot] = k;
      dir_stamp[r.slot] = now;
      dir_count++;
    end
    return r;
  endfunction

  // Driver. Inputs move on the falling edge. A request stays on the port
  // until it is taken; after that the next one follows at once inside a
  // burst, or after a random gap between bursts. Gaps run from none up to
  // beyond the busy time, so they land on every phase of the scan.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || req_taken)) begin
      if (gap_left > 0 || key_queue.size() == 0) begin
        start <= 1'b0;
        key_i <= $urandom();      // noise on an idle port must be ignored
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        key_i <= key_queue.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
    end
  end

  // Monitor. The result of an earlier request is checked before a request
  // accepted at the same edge is predicted, so the queue order always holds.
  always @(posedge clk_i) begin
    cache_outcome_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (done_o === 1'b1) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no request outstanding: %b %0d %b %h",
                     $realtime, hit_o, slot_o, evicted_o, evicted_key_o);
        end else begin
          want = outcome_q.pop_front();
          served_count++;
          if (hit_o !== want.hit || slot_o !== want.slot ||
              evicted_o !== want.evicted || evicted_key_o !== want.evicted_key) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("%0t: key %h expected hit %b slot %0d evicted %b key %h, ",
                     $realtime, want.key, want.hit, want.slot, want.evicted,
                     want.evicted_key);
              $display("got hit %b slot %0d evicted %b key %h",
                       hit_o, slot_o, evicted_o, evicted_key_o);
            end
          end
        end
      end
      if (start && busy === 1'b0) begin
        outcome_q.push_back(predict_access(key_i));
        req_taken <= 1'b1;
      end else begin
        req_taken <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_key(logic [KEY_BITS-1:0] k);
    key_queue.push_back(k);
    issued_count++;
  endtask

  // Returns once every request handed out so far has produced its result.
  task automatic wait_idle();
    do @(negedge clk_i); while (served_count != issued_count);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    capacity_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= CAP_W'($urandom());
  endtask

  // Random traffic over a working set sized around the capacity, so that
  // hits, fills and evictions all occur. Some working sets fit inside the
  // capacity (mostly hits), most overflow it (steady replacement). Neighbor
  // keys that differ in one bit exercise the tag compare.
  task automatic send_random(int unsigned count);
    logic [KEY_BITS-1:0] pool [$];
    int unsigned         eff;
    int unsigned         pool_n;
    eff = effective_capacity();
    if ($urandom_range(0, 3) == 0)
      pool_n = $urandom_range(1, eff);
    else
      pool_n = eff + $urandom_range(1, eff / 2 + 4);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0: pool.push_back(i[0] ? '1 : '0);
        1, 2: pool.push_back((i > 0) ?
                pool[i-1] ^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS-1)) :
                $urandom());
        default: pool.push_back($urandom());
      endcase
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < 85)
        send_key(pool[$urandom_range(0, pool_n - 1)]);
      else
        send_key($urandom());
    end
  endtask

  initial begin
    int unsigned caps [6] = '{127, 1, 64, 100, 16, 40};

    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_tag[i] = '0;
      dir_stamp[i] = '0;
    end
    dir_count = 0;
    use_clock = '0;
    capacity_reg = ltc_pkg::CAP_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: extreme keys, first fills and hits on them.
    send_key('0);
    send_key('1);
    send_key('0);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key('1);
    send_key(32'h0000_0001);
    // Enough traffic to fill the whole directory and start replacing.
    send_random(200);
    wait_idle();

    // Capacity lowered far below the entry count: every miss swaps one
    // entry for another and the count stays put.
    write_capacity(7'd3);
    send_key(32'h0000_00a0);
    send_key(32'h0000_00b0);
    send_key(32'h0000_00a0);
    send_key(32'h0000_00c0);
    send_random(130);
    wait_idle();

    // Capacity zero behaves as a single entry.
    write_capacity(7'd0);
    send_key(32'h0000_0005);
    send_key(32'h0000_0005);
    send_key(32'h0000_0006);
    send_key(32'h0000_0005);
    send_random(100);
    wait_idle();

    // Two entries: the least recently used one is the one replaced.
    write_capacity(7'd2);
    send_key(32'd10);
    send_key(32'd20);
    send_key(32'd10);
    send_key(32'd30);
    send_key(32'd20);
    send_random(130);
    wait_idle();

    // Fixed settings, including values above the directory size.
    foreach (caps[i]) begin
      write_capacity(CAP_W'(caps[i]));
      send_random((caps[i] >= ENTRIES) ? 200 : 130);
      wait_idle();
    end

    repeat (4) begin
      write_capacity(CAP_W'($urandom_range(0, 127)));
      send_random(40);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (outcome_q.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ lru_tag_cache.f @@
hdl/ltc_pkg.sv
hdl/ltc_ram.sv
hdl/ltc_scan.sv
hdl/lru_tag_cache.sv
verif/lru_tag_cache_test.sv
